FILE: src/aes_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES package
// Word types, register indexes, S-box tables and round helper functions.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int MaxRkWords = 60;
  localparam int CfgIdxW    = 3;
  localparam int CfgDataW   = 64;

  localparam logic [CfgIdxW-1:0] REG_KEY_SIZE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_KEY_01   = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_KEY_23   = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_KEY_45   = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_KEY_67   = 3'd4;

  localparam logic [1:0] KS_192 = 2'd1;
  localparam logic [1:0] KS_256 = 2'd2;

  typedef struct packed {
    logic        kind;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_word_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_word_t;

  localparam logic [7:0] FWD_SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    sub_word = {FWD_SBOX[w[31:24]], FWD_SBOX[w[23:16]], FWD_SBOX[w[15:8]], FWD_SBOX[w[7:0]]};
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    xt = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] mix_col(input logic [31:0] c, input logic inv);
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [7:0] r [4];
    for (int k = 0; k < 4; k++) begin
      a[k]  = c[31-8*k -: 8];
      a2[k] = xt(a[k]);
      a4[k] = xt(a2[k]);
      a8[k] = xt(a4[k]);
      m2[k] = a2[k];
      m3[k] = a2[k] ^ a[k];
      m9[k] = a8[k] ^ a[k];
      mb[k] = a8[k] ^ a2[k] ^ a[k];
      md[k] = a8[k] ^ a4[k] ^ a[k];
      me[k] = a8[k] ^ a4[k] ^ a2[k];
    end
    for (int q = 0; q < 4; q++) begin
      if (inv) begin
        r[q] = me[q] ^ mb[(q+1)%4] ^ md[(q+2)%4] ^ m9[(q+3)%4];
      end else begin
        r[q] = m2[q] ^ m3[(q+1)%4] ^ a[(q+2)%4] ^ a[(q+3)%4];
      end
    end
    mix_col = {r[0], r[1], r[2], r[3]};
  endfunction

endpackage : aes_pkg
`default_nettype wire

FILE: src/aes_block_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES block cipher
// Iterative AES-128/192/256 encrypt and decrypt with a stored key schedule.
// ----------------------------------------------------------------------------
// Channel   Ports                              Direction  Handshake
// input     start, busy, in_word               in         start && !busy
// result    out_valid, out_word                out        one-cycle strobe
// config    cfg_we, cfg_idx, cfg_data          in         write on cfg_we
//
// A round needs 4 key words and the round key store has one registered read
// port, so each round first fetches them in S_KEY (four reads plus one more
// step for the last read to land) and then applies them in the shared round
// unit in S_RND. A block holds busy until its result is taken into out_r in
// S_OUT, and out_valid is registered from S_OUT.
// After reset or any write to the key size or key registers, the next block
// first expands the key schedule in S_EXP, one word per cycle.
// Reset is synchronous and clears the control state and the key config.
// The receiver cannot stall; each result shows on out_valid for one cycle.
// ----------------------------------------------------------------------------
module aes_block_cipher import aes_pkg::*; #(
  parameter int RkWords = MaxRkWords
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  output logic                     busy,
  input  wire in_word_t            in_word,
  output logic                     out_valid,
  output out_word_t                out_word,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_idx,
  input  wire logic [CfgDataW-1:0] cfg_data
);

  localparam int RkIdxW = $clog2(RkWords + 1);
  localparam int AddrW  = $clog2(RkWords);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXP  = 3'd1;
  localparam logic [2:0] S_KEY  = 3'd2;  // fetch four key words
  localparam logic [2:0] S_RND  = 3'd3;  // apply one round
  localparam logic [2:0] S_OUT  = 3'd4;

  logic [2:0]   st_r, st_nxt;
  logic [1:0]   ksz_r;
  logic [255:0] key_r;
  logic         cur_r, cur_nxt;
  logic         enc_r;
  logic [127:0] s_r, s_nxt;
  logic [3:0]   rnd_r, rnd_nxt;   // rounds completed
  logic [2:0]   kc_r, kc_nxt;     // key word fetch counter
  logic [127:0] rk_r;
  logic [31:0]  rd_r;
  logic         rd_ok_r;
  logic [31:0]  store [RkWords];
  logic         out_valid_r;
  out_word_t    out_r;

  logic         exp_go, exp_busy, exp_we;
  logic [RkIdxW-1:0] exp_idx;
  logic [31:0]  exp_data;
  logic [3:0]   nr;
  logic [3:0]   krnd;
  logic [5:0]   raddr;

  aes_key_exp #(.RkWords(RkWords)) u_kexp (
    .clk, .rst_n, .go(exp_go), .key_size(ksz_r), .key(key_r),
    .busy(exp_busy), .wr_en(exp_we), .wr_idx(exp_idx), .wr_data(exp_data)
  );

  assign nr = (ksz_r == KS_192) ? 4'd12 : ((ksz_r == KS_256) ? 4'd14 : 4'd10);
  // decryption walks the schedule backwards
  assign krnd = enc_r ? rnd_r : nr - rnd_r;
  assign raddr = 6'(4 * int'(krnd) + int'(kc_r));

  // store: one write port from the expander, one registered read port
  always_ff @(posedge clk) begin
    if (exp_we) begin
      store[exp_idx[AddrW-1:0]] <= exp_data;
    end
    rd_ok_r <= raddr < 6'(RkWords);
    rd_r <= store[raddr[AddrW-1:0]];
  end

  // shared round unit
  always_comb begin
    logic [31:0] c [4];
    logic [31:0] sh [4];
    logic [31:0] sb [4];
    logic [31:0] mx [4];
    logic        first, last;
    first = (rnd_r == 4'd0);
    last  = (rnd_r == nr);
    for (int k = 0; k < 4; k++) begin
      c[k] = s_r[127-32*k -: 32];
    end
    for (int k = 0; k < 4; k++) begin
      for (int q = 0; q < 4; q++) begin
        if (enc_r) begin
          sh[k][31-8*q -: 8] = FWD_SBOX[c[(k+q)%4][31-8*q -: 8]];
        end else begin
          sh[k][31-8*q -: 8] = INV_SBOX[c[(k+4-q)%4][31-8*q -: 8]];
        end
      end
    end
    for (int k = 0; k < 4; k++) begin
      if (first) begin
        sb[k] = c[k];
      end else begin
        sb[k] = sh[k];
      end
      if (enc_r) begin
        mx[k] = (first || last) ? (sb[k] ^ rk_r[127-32*k -: 32])
                                : (mix_col(sb[k], 1'b0) ^ rk_r[127-32*k -: 32]);
      end else begin
        mx[k] = (first || last) ? (sb[k] ^ rk_r[127-32*k -: 32])
                                : mix_col(sb[k] ^ rk_r[127-32*k -: 32], 1'b1);
      end
    end
    s_nxt = {mx[0], mx[1], mx[2], mx[3]};
  end

  always_comb begin
    st_nxt = st_r;
    cur_nxt = cur_r;
    rnd_nxt = rnd_r;
    kc_nxt = kc_r;
    exp_go = 1'b0;
    unique case (st_r)
      S_IDLE: begin
        if (start) begin
          rnd_nxt = '0;
          kc_nxt = '0;
          if (!cur_r) begin
            exp_go = 1'b1;
            st_nxt = S_EXP;
          end else begin
            st_nxt = S_KEY;
          end
        end
      end
      S_EXP: begin
        if (!exp_busy) begin
          cur_nxt = 1'b1;
          st_nxt = S_KEY;
        end
      end
      S_KEY: begin
        // address kc issued; data arrives from the registered read in the next cycle
        kc_nxt = kc_r + 3'd1;
        if (kc_r == 3'd4) begin
          st_nxt = S_RND;
        end
      end
      S_RND: begin
        kc_nxt = '0;
        rnd_nxt = rnd_r + 4'd1;
        st_nxt = (rnd_r == nr) ? S_OUT : S_KEY;
      end
      S_OUT: begin
        st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
    if (cfg_we && cfg_idx <= REG_KEY_67) begin
      cur_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cur_r <= 1'b0;
      ksz_r <= '0;
      key_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      cur_r <= cur_nxt;
      out_valid_r <= (st_r == S_OUT);
      if (cfg_we) begin
        unique case (cfg_idx)
          REG_KEY_SIZE: ksz_r <= cfg_data[1:0];
          REG_KEY_01:   key_r[255:192] <= cfg_data;
          REG_KEY_23:   key_r[191:128] <= cfg_data;
          REG_KEY_45:   key_r[127:64]  <= cfg_data;
          REG_KEY_67:   key_r[63:0]    <= cfg_data;
          default: ;
        endcase
      end
    end
    rnd_r <= rnd_nxt;
    kc_r <= kc_nxt;
    if (st_r == S_IDLE && start) begin
      enc_r <= in_word.kind;
      s_r <= {in_word.block_high, in_word.block_low};
    end
    // hold fetched key word in its slot, shorter stores read as zero
    if (st_r == S_KEY && kc_r != 3'd0) begin
      rk_r <= {rk_r[95:0], rd_ok_r ? rd_r : 32'h0};
    end
    if (st_r == S_RND) begin
      s_r <= s_nxt;
    end
    if (st_r == S_OUT) begin
      out_r <= '{result_high: s_r[127:64], result_low: s_r[63:0]};
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word = out_r;

endmodule : aes_block_cipher
`default_nettype wire

FILE: src/aes_key_exp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES key expansion
// Produces one round key word per cycle into the caller's store.
// ----------------------------------------------------------------------------
module aes_key_exp import aes_pkg::*; #(
  parameter int RkWords = MaxRkWords,
  localparam int RkIdxW = $clog2(RkWords + 1)
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              go,
  input  wire logic [1:0]        key_size,
  input  wire logic [255:0]      key,
  output logic                   busy,
  output logic                   wr_en,
  output logic [RkIdxW-1:0]      wr_idx,
  output logic [31:0]            wr_data
);

  logic        busy_r, busy_nxt;
  logic [5:0]  i_r, i_nxt;
  logic [3:0]  ph_r, ph_nxt;   // i mod nk
  logic [7:0]  rc_r, rc_nxt;
  logic [31:0] win_r [8];      // sliding window of the last nk words
  logic [3:0]  nk;
  logic [5:0]  total;
  logic [31:0] prev, t;

  always_comb begin
    nk = (key_size == KS_192) ? 4'd6 : ((key_size == KS_256) ? 4'd8 : 4'd4);
    total = 6'(4 * (int'(nk) + 7));
    prev = win_r[3'(nk - 4'd1)];
    t = prev;
    if (ph_r == 4'd0) begin
      t = sub_word({prev[23:0], prev[31:24]}) ^ {rc_r, 24'h0};
    end else if (nk == 4'd8 && ph_r == 4'd4) begin
      t = sub_word(prev);
    end
    if (i_r < 6'(nk)) begin
      wr_data = key[255 - 32*i_r -: 32];
    end else begin
      wr_data = win_r[0] ^ t;
    end
    busy_nxt = busy_r;
    i_nxt = i_r;
    ph_nxt = ph_r;
    rc_nxt = rc_r;
    if (!busy_r) begin
      if (go) begin
        busy_nxt = 1'b1;
        i_nxt = '0;
        ph_nxt = '0;
        rc_nxt = 8'h01;
      end
    end else begin
      i_nxt = i_r + 6'd1;
      if (ph_r == nk - 4'd1) begin
        ph_nxt = '0;
      end else begin
        ph_nxt = ph_r + 4'd1;
      end
      if (i_r >= 6'(nk) && ph_r == 4'd0) begin
        rc_nxt = xt(rc_r);
      end
      if (i_r == total - 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign wr_en = busy_r && (i_r < 6'(RkWords));
  assign wr_idx = RkIdxW'(i_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    i_r  <= i_nxt;
    ph_r <= ph_nxt;
    rc_r <= rc_nxt;
    if (busy_r) begin
      // shift the window: slot nk-1 is the newest word
      for (int k = 0; k < 7; k++) begin
        win_r[k] <= (4'(k) == nk - 4'd1) ? wr_data : win_r[k+1];
      end
      win_r[7] <= wr_data;
    end
  end

endmodule : aes_key_exp
`default_nettype wire
